// ===== sv/mmm_pkg.sv =====
// ----------------------------------------------------------------------------
// mmm_pkg: shared definitions for the min/median/max sorter
// Default sizes and the control word that the sorter drives into its cells.
// ----------------------------------------------------------------------------
package mmm_pkg;

  localparam int DEPTH_DEF        = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the broadcast sample into sorted position
    logic shift;   // every cell takes its upper neighbor's value; the top cell keeps its own
    logic clear;   // drop all entries
  } cell_ctrl_t;

endpackage

// ===== sv/mmm_if.sv =====
// ----------------------------------------------------------------------------
// mmm_in_if / mmm_out_if: valid/ready channels of the min/median/max sorter
// A word moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface mmm_in_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface mmm_out_if #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int COUNT_WIDTH  = 7
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] minimum;
  logic signed [SAMPLE_WIDTH-1:0] median;
  logic signed [SAMPLE_WIDTH-1:0] maximum;
  logic        [COUNT_WIDTH-1:0]  set_count;
  logic                           overflow;

  modport source (output valid, output minimum, output median, output maximum,
                  output set_count, output overflow, input ready);
  modport sink   (input valid, input minimum, input median, input maximum,
                  input set_count, input overflow, output ready);
endinterface

// ===== sv/mmm_cell.sv =====
// ----------------------------------------------------------------------------
// mmm_cell: one storage cell of the insertion chain
// Holds one sorted value; on insert it keeps, takes the new sample or takes
// the lower neighbor's value; on shift it takes the upper neighbor's value; clear empties it.
// ----------------------------------------------------------------------------
module mmm_cell #(
  parameter int SAMPLE_WIDTH = mmm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mmm_pkg::cell_ctrl_t            ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [SAMPLE_WIDTH-1:0] lower_val,
  input  logic                           lower_gt,
  input  logic                           lower_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] upper_val,
  output logic signed [SAMPLE_WIDTH-1:0] val,
  output logic                           gt,
  output logic                           valid
);
  import mmm_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] val_r, val_nxt;
  logic                           valid_r, valid_nxt;

  // An empty cell counts as larger than any sample.
  assign gt = !valid_r || (val_r > sample);

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctrl.insert && gt) begin
      val_nxt   = lower_gt ? lower_val : sample;
      valid_nxt = valid_r | lower_valid;
    end else if (ctrl.shift) begin
      val_nxt = upper_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val   = val_r;
  assign valid = valid_r;

endmodule

// ===== sv/mmm_chain.sv =====
// ----------------------------------------------------------------------------
// mmm_chain: row of sorting cells
// Keeps the loaded samples in ascending order from cell 0 upward and shows
// the two lowest cells, which the drain shift brings the middle values into.
// ----------------------------------------------------------------------------
module mmm_chain #(
  parameter int DEPTH        = mmm_pkg::DEPTH_DEF,
  parameter int SAMPLE_WIDTH = mmm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mmm_pkg::cell_ctrl_t            ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic signed [SAMPLE_WIDTH-1:0] val0,
  output logic signed [SAMPLE_WIDTH-1:0] val1
);
  import mmm_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] vals  [DEPTH];
  logic                           gts   [DEPTH];
  logic                           valids[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] lower_val;
    logic signed [SAMPLE_WIDTH-1:0] upper_val;
    logic                           lower_gt;
    logic                           lower_valid;

    if (i == 0) begin : g_bottom
      assign lower_val   = sample;
      assign lower_gt    = 1'b0;
      assign lower_valid = 1'b1;
    end else begin : g_mid
      assign lower_val   = vals[i-1];
      assign lower_gt    = gts[i-1];
      assign lower_valid = valids[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign upper_val = vals[i];
    end else begin : g_below_top
      assign upper_val = vals[i+1];
    end

    mmm_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .sample     (sample),
      .lower_val  (lower_val),
      .lower_gt   (lower_gt),
      .lower_valid(lower_valid),
      .upper_val  (upper_val),
      .val        (vals[i]),
      .gt         (gts[i]),
      .valid      (valids[i])
    );
  end

  assign val0 = vals[0];
  assign val1 = vals[1];

endmodule

// ===== sv/min_median_max_of_set.sv =====
// ----------------------------------------------------------------------------
// min_median_max_of_set: minimum, median and maximum of a set of samples
// Insertion-sorting cell chain with a drain shift to reach the median.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one signed sample per word; last marks the end of a set.
//   While loading, one word is taken every cycle: the sample is compared
//   against all cells at once and slots into place in that same cycle.
//   Samples beyond DEPTH are dropped and flagged in overflow.
//   After the word with last, the chain shifts down (n-1)/2 times, one
//   cell per cycle, so the middle values reach the two bottom cells; then
//   the median is formed and loaded into the output register once that
//   register is free. Here n is the kept count; in_ch is held off until
//   the output register has been loaded.
//   out_ch gives one word per set. Its register frees the chain at once,
//   so the next set loads while a result waits; if a second result is
//   ready before the first is taken, the drain holds in its last cycle.
//   Reset empties the set and the output register; no clearing pass.
// ----------------------------------------------------------------------------
module min_median_max_of_set #(
  parameter int DEPTH        = mmm_pkg::DEPTH_DEF,
  parameter int SAMPLE_WIDTH = mmm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mmm_in_if.sink     in_ch,
  mmm_out_if.source  out_ch
);
  import mmm_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = $clog2(DEPTH);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                           state_r, state_nxt;
  logic [CW-1:0]                  fill_r, fill_nxt;
  logic                           dropped_r, dropped_nxt;
  logic [KW-1:0]                  k_r, k_nxt;
  logic signed [SAMPLE_WIDTH-1:0] min_r, min_nxt;
  logic signed [SAMPLE_WIDTH-1:0] max_r, max_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_min_r, out_med_r, out_max_r;
  logic [CW-1:0]                  out_cnt_r;
  logic                           out_ovf_r;

  cell_ctrl_t                     ctrl;
  logic signed [SAMPLE_WIDTH-1:0] val0, val1;
  logic signed [SAMPLE_WIDTH:0]   mid_sum;
  logic signed [SAMPLE_WIDTH-1:0] median;
  logic                           accept, full, finish;
  logic [CW-1:0]                  n_new;

  mmm_chain #(
    .DEPTH       (DEPTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .sample(in_ch.sample),
    .val0  (val0),
    .val1  (val1)
  );

  assign in_ch.ready = (state_r == ST_LOAD);
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (fill_r == CW'(DEPTH));
  assign n_new       = full ? fill_r : fill_r + 1'b1;
  assign finish      = (state_r == ST_DRAIN) && (k_r == '0) &&
                       (!out_valid_r || out_ch.ready);

  // Floor mean of the two middles: full-width sum, arithmetic shift by one.
  assign mid_sum = {val0[SAMPLE_WIDTH-1], val0} + {val1[SAMPLE_WIDTH-1], val1};
  assign median  = fill_r[0] ? val0 : mid_sum[SAMPLE_WIDTH:1];

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    dropped_nxt = dropped_r;
    k_nxt       = k_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    ctrl        = '0;
    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            ctrl.insert = 1'b1;
            fill_nxt    = fill_r + 1'b1;
            if (fill_r == '0 || in_ch.sample < min_r) begin
              min_nxt = in_ch.sample;
            end
            if (fill_r == '0 || in_ch.sample > max_r) begin
              max_nxt = in_ch.sample;
            end
          end
          if (in_ch.last) begin
            k_nxt     = KW'((n_new - 1'b1) >> 1);
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (k_r != '0) begin
          ctrl.shift = 1'b1;
          k_nxt      = k_r - 1'b1;
        end else if (finish) begin
          ctrl.clear  = 1'b1;
          fill_nxt    = '0;
          dropped_nxt = 1'b0;
          state_nxt   = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      fill_r      <= '0;
      dropped_r   <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      dropped_r   <= dropped_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    min_r <= min_nxt;
    max_r <= max_nxt;
    if (finish) begin
      out_min_r <= min_r;
      out_med_r <= median;
      out_max_r <= max_r;
      out_cnt_r <= fill_r;
      out_ovf_r <= dropped_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.minimum   = out_min_r;
  assign out_ch.median    = out_med_r;
  assign out_ch.maximum   = out_max_r;
  assign out_ch.set_count = out_cnt_r;
  assign out_ch.overflow  = out_ovf_r;

endmodule

// ===== sv/mmm_check.sv =====
// ----------------------------------------------------------------------------
// mmm_check: port-level checks of the min/median/max sorter
// Watches both channels and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module mmm_check #(
  parameter int DEPTH        = mmm_pkg::DEPTH_DEF,
  parameter int SAMPLE_WIDTH = mmm_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = $clog2(DEPTH + 1)
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_last,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_WIDTH-1:0] out_minimum,
  input logic signed [SAMPLE_WIDTH-1:0] out_median,
  input logic signed [SAMPLE_WIDTH-1:0] out_maximum,
  input logic [COUNT_WIDTH-1:0]         out_set_count
);

  // A waiting result word is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn while stalled");

  // The median lies between the extremes of its set.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_minimum <= out_median) && (out_median <= out_maximum))
    else $error("median outside minimum..maximum");

  // A result always covers at least one and at most DEPTH samples.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_set_count != '0) &&
                  (out_set_count <= COUNT_WIDTH'(DEPTH)))
    else $error("set count out of range");

  // The end of a set is followed by the drain state, with the input held off.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after the end of a set");

endmodule

bind min_median_max_of_set mmm_check #(
  .DEPTH       (DEPTH),
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_mmm_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_last      (in_ch.last),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_minimum  (out_ch.minimum),
  .out_median   (out_ch.median),
  .out_maximum  (out_ch.maximum),
  .out_set_count(out_ch.set_count)
);

// ===== bench/min_median_max_of_set_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_median_max_of_set_test: self-checking bench for the min/median/max sorter
// Sends sets of signed Q16.16 samples, predicts each set's minimum, median,
// maximum, kept count and overflow flag, and compares every result word.
// ----------------------------------------------------------------------------
module min_median_max_of_set_test;

  import mmm_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int SAMPLE_W    = SAMPLE_WIDTH_DEF;
  localparam int COUNT_W     = 7;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic signed [SAMPLE_W-1:0] MAX_Q   = 32'h7fffffff;
  localparam logic signed [SAMPLE_W-1:0] MIN_Q   = 32'h80000000;
  localparam logic signed [SAMPLE_W-1:0] NEG_ONE = 32'hffffffff;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] median;
    logic signed [SAMPLE_W-1:0] maximum;
    logic [COUNT_W-1:0]         set_count;
    logic                       overflow;
  } set_stats_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       typed;
    set_stats_t                 stats;
  } stim_row_t;

  logic clk;
  logic rst_n;

  mmm_in_if  #(.SAMPLE_WIDTH(SAMPLE_W))                        in_ch ();
  mmm_out_if #(.SAMPLE_WIDTH(SAMPLE_W), .COUNT_WIDTH(COUNT_W)) out_ch ();

  min_median_max_of_set #(
    .DEPTH        (DEPTH),
    .SAMPLE_WIDTH (SAMPLE_W)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: the kept samples in ascending order.
  logic signed [SAMPLE_W-1:0] sorted_vals [DEPTH];
  int                         kept_count;
  logic                       drop_seen;
  logic signed [SAMPLE_W-1:0] prev_pick;

  set_stats_t pending_stats [$];

  int  error_count;
  int  words_sent;
  int  sets_sent;
  int  full_sets;
  int  results_checked;
  int  cycle_count = 0;
  bit  in_idling;
  bit  out_idling;
  bit  hold_off;
  bit  pressure_go;

  stim_row_t stim_rows [0:22];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_stats.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("Mismatch at %0t in %s: got %0d, expected %0d", $realtime, field, got, want);
    error_count++;
  endtask

  // Takes one accepted word into the sorted set; on the last word of a set it
  // returns the set's statistics and empties the set.
  task automatic load_sample(input logic signed [SAMPLE_W-1:0] s, input logic is_last,
                             output bit done, output set_stats_t res);
    int                         pos;
    int                         n;
    logic signed [SAMPLE_W:0]   pair_sum;
    done = 1'b0;
    res  = '0;
    if (kept_count < DEPTH) begin
      pos = kept_count;
      while (pos > 0 && sorted_vals[pos-1] > s) begin
        sorted_vals[pos] = sorted_vals[pos-1];
        pos--;
      end
      sorted_vals[pos] = s;
      kept_count++;
    end else begin
      drop_seen = 1'b1;
    end
    if (is_last) begin
      n = kept_count;
      if (n % 2 == 1) begin
        res.median = sorted_vals[(n-1)/2];
      end else begin
        // Floor of the mean: the 33-bit sum shifted right with its sign.
        pair_sum   = {sorted_vals[n/2-1][SAMPLE_W-1], sorted_vals[n/2-1]}
                   + {sorted_vals[n/2][SAMPLE_W-1], sorted_vals[n/2]};
        res.median = pair_sum[SAMPLE_W:1];
      end
      res.minimum   = sorted_vals[0];
      res.maximum   = sorted_vals[n-1];
      res.set_count = n[COUNT_W-1:0];
      res.overflow  = drop_seen;
      done          = 1'b1;
      kept_count    = 0;
      drop_seen     = 1'b0;
    end
  endtask

  task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic is_last,
                           input bit typed, input set_stats_t typed_stats);
    bit         done;
    set_stats_t res;
    set_stats_t want_stats;
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    in_ch.last   <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    load_sample(s, is_last, done, res);
    if (done) begin
      sets_sent++;
      if (res.overflow) full_sets++;
      want_stats    = typed ? typed_stats : res;
      pending_stats = {pending_stats, want_stats};
    end
    if (in_idling && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        v = MAX_Q;
      end
      1: begin
        v = MIN_Q;
      end
      2: begin
        v = $signed($urandom_range(0, 16)) - 8;
      end
      3: begin
        v = prev_pick;
      end
      default: begin
        v = $urandom;
      end
    endcase
    prev_pick = v;
    return v;
  endfunction

  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) begin
      send_word(pick_sample(), i == len - 1, 1'b0, '0);
    end
  endtask

  function automatic int pick_set_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 8);
    if (r < 9) return $urandom_range(9, 40);
    return $urandom_range(60, 72);
  endfunction

  task automatic send_random_sets(input int word_goal, input bit vary_idling);
    while (words_sent < word_goal) begin
      if (vary_idling) begin
        in_idling  = ($urandom_range(0, 4) != 0);
        out_idling <= ($urandom_range(0, 4) != 0);
      end
      send_set(pick_set_length());
    end
  endtask

  // Result side: check each accepted word, then pick the next ready.
  initial begin
    int         burst;
    bit         ready_next;
    set_stats_t got;
    set_stats_t want;
    burst        = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.minimum, out_ch.median, out_ch.maximum,
                out_ch.set_count, out_ch.overflow};
        if (pending_stats.size() == 0) begin
          report_mismatch("result words", results_checked + 1, results_checked);
        end else begin
          want = pending_stats.pop_front();
          results_checked++;
          if (got.minimum !== want.minimum)
            report_mismatch("minimum", got.minimum, want.minimum);
          if (got.median !== want.median)
            report_mismatch("median", got.median, want.median);
          if (got.maximum !== want.maximum)
            report_mismatch("maximum", got.maximum, want.maximum);
          if (got.set_count !== want.set_count)
            report_mismatch("set_count", got.set_count, want.set_count);
          if (got.overflow !== want.overflow)
            report_mismatch("overflow", got.overflow, want.overflow);
        end
      end
      if (!rst_n || hold_off) begin
        ready_next = 1'b0;
      end else if (burst > 0) begin
        burst--;
        ready_next = 1'b0;
      end else if (out_idling && $urandom_range(0, 5) == 0) begin
        burst      = $urandom_range(1, 3) - 1;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ch.ready <= ready_next;
    end
  end

  // Long receiver hold-off so that results back up and the input stalls.
  initial begin
    hold_off <= 1'b0;
    @(posedge clk iff pressure_go);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    stim_rows[0]  = '{MAX_Q,   1'b1, 1'b1, '{MAX_Q, MAX_Q, MAX_Q, 7'd1, 1'b0}};
    stim_rows[1]  = '{MIN_Q,   1'b1, 1'b1, '{MIN_Q, MIN_Q, MIN_Q, 7'd1, 1'b0}};
    stim_rows[2]  = '{MIN_Q,   1'b0, 1'b0, '0};
    stim_rows[3]  = '{MAX_Q,   1'b1, 1'b1, '{MIN_Q, NEG_ONE, MAX_Q, 7'd2, 1'b0}};
    stim_rows[4]  = '{32'sd0,  1'b0, 1'b0, '0};
    stim_rows[5]  = '{NEG_ONE, 1'b1, 1'b1, '{NEG_ONE, NEG_ONE, 32'sd0, 7'd2, 1'b0}};
    stim_rows[6]  = '{MAX_Q,   1'b0, 1'b0, '0};
    stim_rows[7]  = '{MAX_Q,   1'b1, 1'b1, '{MAX_Q, MAX_Q, MAX_Q, 7'd2, 1'b0}};
    stim_rows[8]  = '{MIN_Q,   1'b0, 1'b0, '0};
    stim_rows[9]  = '{MIN_Q,   1'b1, 1'b1, '{MIN_Q, MIN_Q, MIN_Q, 7'd2, 1'b0}};
    stim_rows[10] = '{32'sd5,  1'b0, 1'b0, '0};
    stim_rows[11] = '{32'sd5,  1'b0, 1'b0, '0};
    stim_rows[12] = '{32'sd5,  1'b1, 1'b1, '{32'sd5, 32'sd5, 32'sd5, 7'd3, 1'b0}};
    stim_rows[13] = '{32'sd4,  1'b0, 1'b0, '0};
    stim_rows[14] = '{32'sd3,  1'b0, 1'b0, '0};
    stim_rows[15] = '{32'sd2,  1'b0, 1'b0, '0};
    stim_rows[16] = '{32'sd1,  1'b0, 1'b0, '0};
    stim_rows[17] = '{32'sd0,  1'b1, 1'b0, '0};
    stim_rows[18] = '{32'sd10, 1'b0, 1'b0, '0};
    stim_rows[19] = '{-32'sd10, 1'b0, 1'b0, '0};
    stim_rows[20] = '{32'sd3,  1'b0, 1'b0, '0};
    stim_rows[21] = '{-32'sd3, 1'b1, 1'b0, '0};
    stim_rows[22] = '{32'sh00018000, 1'b1, 1'b0, '0};

    kept_count      = 0;
    drop_seen       = 1'b0;
    prev_pick       = '0;
    error_count     = 0;
    words_sent      = 0;
    sets_sent       = 0;
    full_sets       = 0;
    results_checked = 0;
    in_idling       = 1'b1;
    out_idling      <= 1'b1;
    pressure_go     <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.sample    <= '0;
    in_ch.last      <= 1'b0;
    rst_n           <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      send_word(stim_rows[i].sample, stim_rows[i].last, stim_rows[i].typed,
                stim_rows[i].stats);
    end

    // Sets that fill the store exactly, drop one word (the last one) and drop the last two.
    send_set(DEPTH);
    send_set(DEPTH + 1);
    send_set(DEPTH + 2);

    send_random_sets(600, 1'b1);

    // Short sets back to back while the receiver holds off.
    in_idling   = 1'b0;
    out_idling  <= 1'b0;
    pressure_go <= 1'b1;
    for (int k = 0; k < 30; k++) begin
      send_set($urandom_range(1, 4));
    end

    send_random_sets(780, 1'b1);

    in_idling  = 1'b0;
    out_idling <= 1'b0;
    send_random_sets(900, 1'b0);
    in_ch.valid <= 1'b0;

    while (pending_stats.size() != 0) @(posedge clk);
    repeat (2 * DEPTH) @(posedge clk);

    $display("Sent %0d words in %0d sets, %0d of them past the %0d-entry store;",
             words_sent, sets_sent, full_sets, DEPTH);
    $display("checked %0d results, including a long receiver hold-off.", results_checked);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
